// ----- rtl/pppdf_pkg.sv -----
// Package with the shared types and constants of the PPP frame deframer.
`default_nettype none

package pppdf_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;

   // Header layout: three big-endian words, six bytes.
   localparam logic [WORD_W-1:0] HDR_TOTAL_HI  = 16'd0;
   localparam logic [WORD_W-1:0] HDR_TOTAL_LO  = 16'd1;
   localparam logic [WORD_W-1:0] HDR_MARKER_HI = 16'd2;
   localparam logic [WORD_W-1:0] HDR_MARKER_LO = 16'd3;
   localparam logic [WORD_W-1:0] HDR_PLEN_HI   = 16'd4;
   localparam logic [WORD_W-1:0] HDR_PLEN_LO   = 16'd5;
   localparam logic [WORD_W:0]   HEADER_BYTES  = 17'd6;

   localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET = 16'd16384;
   localparam logic [WORD_W-1:0] MARKER_RESET      = 16'h5050;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER      = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_BAD_HDR   = 2'd2,
      KIND_OVERSIZE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_last;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/pppdf_if.sv -----
// Channel interfaces for the deframer's request and response items.
`default_nettype none

interface pppdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface pppdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic       frame_last;

   modport source (output valid, output kind, output payload_byte, output frame_last,
                   input ready);
   modport sink   (input valid, input kind, input payload_byte, input frame_last,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/pppdf_core.sv -----
// Header parser, payload counter and configuration registers of the deframer.
`default_nettype none

module pppdf_core
   import pppdf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   input  wire logic                 step,
   input  wire logic [BYTE_W-1:0]    rx_byte,
   input  wire logic                 chunk_end,
   output logic                      res_valid,
   output result_type                res
);

   logic [WORD_W-1:0] max_payload_ff, max_payload_in;
   logic [WORD_W-1:0] marker_word_ff, marker_word_in;
   logic              in_payload_ff, in_payload_in;
   logic [WORD_W-1:0] byte_count_ff, byte_count_in;
   logic [WORD_W-1:0] total_length_ff, total_length_in;
   logic [WORD_W-1:0] marker_seen_ff, marker_seen_in;
   logic [WORD_W-1:0] payload_length_ff, payload_length_in;
   logic              discarding_ff, discarding_in;

   logic [WORD_W-1:0] plen_new;
   logic [WORD_W:0]   expected_total;
   logic [WORD_W-1:0] count_inc;

   assign plen_new       = {payload_length_ff[WORD_W-1:BYTE_W], rx_byte};
   assign expected_total = {1'b0, plen_new} + HEADER_BYTES;
   assign count_inc      = byte_count_ff + 16'd1;

   always_comb begin
      max_payload_in = max_payload_ff;
      marker_word_in = marker_word_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD: max_payload_in = csr_wdata;
            CSR_MARKER:      marker_word_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_payload_in     = in_payload_ff;
      byte_count_in     = byte_count_ff;
      total_length_in   = total_length_ff;
      marker_seen_in    = marker_seen_ff;
      payload_length_in = payload_length_ff;
      discarding_in     = discarding_ff;
      res_valid         = 1'b0;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = '0;
      res.frame_last    = 1'b0;

      if (step) begin
         if (discarding_ff) begin
            if (chunk_end) begin
               discarding_in = 1'b0;
            end
         end else if (!in_payload_ff) begin
            case (byte_count_ff)
               HDR_TOTAL_HI:  total_length_in = {rx_byte, total_length_ff[BYTE_W-1:0]};
               HDR_TOTAL_LO:  total_length_in = {total_length_ff[WORD_W-1:BYTE_W], rx_byte};
               HDR_MARKER_HI: marker_seen_in = {rx_byte, marker_seen_ff[BYTE_W-1:0]};
               HDR_MARKER_LO: marker_seen_in = {marker_seen_ff[WORD_W-1:BYTE_W], rx_byte};
               HDR_PLEN_HI:   payload_length_in = {rx_byte, payload_length_ff[BYTE_W-1:0]};
               default:       payload_length_in = plen_new;
            endcase

            if (byte_count_ff != HDR_PLEN_LO) begin
               byte_count_in = count_inc;
            end else begin
               byte_count_in = '0;
               // Consistency is checked before size, so a header failing both
               // reports as inconsistent.
               if (({1'b0, total_length_ff} != expected_total) ||
                   (marker_seen_ff != marker_word_ff)) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_BAD_HDR;
                  discarding_in     = !chunk_end;
                  total_length_in   = '0;
                  marker_seen_in    = '0;
                  payload_length_in = '0;
               end else if (plen_new > max_payload_ff) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_OVERSIZE;
                  discarding_in     = !chunk_end;
                  total_length_in   = '0;
                  marker_seen_in    = '0;
                  payload_length_in = '0;
               end else if (plen_new == '0) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_EMPTY;
                  res.frame_last    = 1'b1;
                  total_length_in   = '0;
                  marker_seen_in    = '0;
                  payload_length_in = '0;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end else begin
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
            if (count_inc >= payload_length_ff) begin
               res.frame_last    = 1'b1;
               in_payload_in     = 1'b0;
               byte_count_in     = '0;
               total_length_in   = '0;
               marker_seen_in    = '0;
               payload_length_in = '0;
            end else begin
               byte_count_in = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff    <= MAX_PAYLOAD_RESET;
         marker_word_ff    <= MARKER_RESET;
         in_payload_ff     <= 1'b0;
         byte_count_ff     <= '0;
         total_length_ff   <= '0;
         marker_seen_ff    <= '0;
         payload_length_ff <= '0;
         discarding_ff     <= 1'b0;
      end else begin
         max_payload_ff    <= max_payload_in;
         marker_word_ff    <= marker_word_in;
         in_payload_ff     <= in_payload_in;
         byte_count_ff     <= byte_count_in;
         total_length_ff   <= total_length_in;
         marker_seen_ff    <= marker_seen_in;
         payload_length_ff <= payload_length_in;
         discarding_ff     <= discarding_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pppdf_rsp_stage.sv -----
// Result register that holds one item until the response side takes it.
`default_nettype none

module pppdf_rsp_stage
   import pppdf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type load_data,
   input  wire logic       out_ready,
   output logic            can_take,
   output logic            out_valid,
   output result_type      out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign can_take = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_take) begin
         valid_in = load;
         if (load) begin
            data_in = load_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/ppp_ssl_frame_deframer.sv -----
// An accepted item waits in the input register until the result register can take; the parser's
// result is then registered there. Throughput: one item per cycle unless results are not taken;
// the parser touches each byte once with a counter and compares.
// Items that produce no result (header bytes, discarded bytes) simply vanish in the parser.
// Reset (synchronous, active high) clears the parser, both registers' valid flags and
// restores the configuration registers to their default values.
`default_nettype none

module ppp_ssl_frame_deframer
   import pppdf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   pppdf_req_if.sink                 req_chan,
   pppdf_rsp_if.source               rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_end_ff, in_end_in;

   logic       can_take;
   logic       step;
   logic       res_valid;
   result_type res;
   result_type out_data;

   // The input register drains into the parser whenever the result register can take.
   assign step           = in_valid_ff && can_take;
   assign req_chan.ready = !in_valid_ff || can_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            in_byte_in = req_chan.rx_byte;
            in_end_in  = req_chan.chunk_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

   pppdf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .chunk_end (in_end_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   pppdf_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .out_ready (rsp_chan.ready),
      .can_take  (can_take),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data)
   );

   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.payload_byte = out_data.payload_byte;
   assign rsp_chan.frame_last   = out_data.frame_last;

   // Only payload items carry a byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind != KIND_PAYLOAD)) |-> (rsp_chan.payload_byte == '0))
      else $error("non-payload item carries a nonzero byte");

   // Error items never close a frame; empty frames always do.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && ((rsp_chan.kind == KIND_BAD_HDR) ||
                          (rsp_chan.kind == KIND_OVERSIZE))) |-> !rsp_chan.frame_last)
      else $error("error item marked as frame end");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_EMPTY)) |-> rsp_chan.frame_last)
      else $error("empty frame item without frame end");

   // Nothing is presented right after reset.
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
